// ===== sv/afs_pkg.sv =====
// afs_pkg: widths, codes, types and helpers shared by the flap scheduler
// used by afs_divider and airspeed_flap_scheduler; depends on nothing

package afs_pkg;

	localparam int unsigned SPEED_W     = 16;
	localparam int unsigned ANGLE_W     = 8;
	localparam int unsigned GAIN_W      = 10;
	localparam int unsigned CFG_DATA_W  = 10;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CMP_W       = 18;
	localparam int unsigned DIFF_W      = 15;
	localparam int unsigned NUM_W       = 23;
	localparam int unsigned DEN_W       = 8;
	localparam int unsigned QUO_W       = 16;
	localparam int unsigned ROLL_PROD_W = 27;
	localparam int unsigned ROLL_TERM_W = ROLL_PROD_W - 8;
	localparam int unsigned CMD_W       = 20;
	localparam int unsigned STEP_CNT_W  = $clog2(NUM_W + 1);

	localparam logic [1:0] MODE_DEFAULT = 2'd0;
	localparam logic [1:0] MODE_FLYING  = 2'd1;

	localparam logic [ANGLE_W-1:0] FULL_ANGLE_RST = 8'd80;
	localparam logic [ANGLE_W-1:0] SPEED_MID_RST  = 8'd10;
	localparam logic [ANGLE_W-1:0] SPEED_MAX_RST  = 8'd20;
	localparam logic [GAIN_W-1:0]  ROLL_GAIN_RST  = 10'd128;

	localparam logic signed [SPEED_W-1:0] PEAK_FLOOR = 16'sh8000;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FULL_ANGLE = 2'd0,
		REG_SPEED_MID  = 2'd1,
		REG_SPEED_MAX  = 2'd2,
		REG_ROLL_GAIN  = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_ROLL,
		ST_MUL_RAMP,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_FINISH
	} state_t;

	// which branch of the schedule the request took
	typedef enum logic [2:0] {
		CL_NONE,
		CL_ZERO,
		CL_RAMP,
		CL_FULL,
		CL_FULL_ROLL
	} sched_class_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	function automatic logic signed [SPEED_W-1:0] sat16(input logic signed [CMD_W-1:0] v);
		logic signed [SPEED_W-1:0] r;
		if (v > CMD_W'(32767))
			r = 16'sh7fff;
		else if (v < -CMD_W'(32768))
			r = 16'sh8000;
		else
			r = v[SPEED_W-1:0];
		return r;
	endfunction

endpackage

// ===== sv/afs_divider.sv =====
// afs_divider: restoring shift-subtract divider, one quotient bit per cycle
// depends on afs_pkg

module afs_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [afs_pkg::NUM_W-1:0]     dividend,
	input  logic [afs_pkg::DEN_W-1:0]     divisor,
	output logic [afs_pkg::QUO_W-1:0]     quotient,
	output afs_pkg::div_status_t          status
);

	logic [afs_pkg::NUM_W-1:0]      num_q;
	logic [afs_pkg::QUO_W-1:0]      quo_q;
	logic [afs_pkg::DEN_W-1:0]      den_q;
	logic [afs_pkg::DEN_W-1:0]      rem_q;
	logic [afs_pkg::STEP_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [afs_pkg::DEN_W:0]        trial;
	logic                           fits;

	// bring down the next dividend bit and try one subtract
	assign trial = {rem_q, num_q[afs_pkg::NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= afs_pkg::STEP_CNT_W'(afs_pkg::NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == afs_pkg::STEP_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[afs_pkg::NUM_W-2:0], 1'b0};
			rem_q <= fits ? afs_pkg::DEN_W'(trial - {1'b0, den_q})
			              : trial[afs_pkg::DEN_W-1:0];
			quo_q <= {quo_q[afs_pkg::QUO_W-2:0], fits};
		end
	end

	// quotient is below 2^16 by construction of the ramp
	assign quotient    = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

// ===== sv/airspeed_flap_scheduler.sv =====
// airspeed_flap_scheduler: flap command from peak airspeed and roll angle
// the sequencer steps through roll multiply then finish, the ramp branch adding ramp
// multiply, divider start and divider wait between them; one request in flight, so a
// new request is taken only once finish finds the result register empty or draining
// reset: config returns to 80 / 10 / 20 / 128, peak airspeed to -32768,
// sequencer to idle and the result register to empty
// depends on afs_pkg and afs_divider

module airspeed_flap_scheduler (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  cfg_we,
	input  logic [afs_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [afs_pkg::CFG_DATA_W-1:0]        cfg_data,
	// sample request channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [1:0]                            flight_mode,
	input  logic signed [afs_pkg::SPEED_W-1:0]    airspeed_sample,
	input  logic signed [afs_pkg::SPEED_W-1:0]    roll_angle,
	// command request channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [afs_pkg::SPEED_W-1:0]    flap_command
);

	// configuration registers
	logic [afs_pkg::ANGLE_W-1:0] full_angle_q;
	logic [afs_pkg::ANGLE_W-1:0] speed_mid_q;
	logic [afs_pkg::ANGLE_W-1:0] speed_max_q;
	logic [afs_pkg::GAIN_W-1:0]  roll_gain_q;

	// sequencer and working registers
	afs_pkg::state_t                    state_q, state_d;
	afs_pkg::sched_class_t              cls_q, cls_d;
	logic signed [afs_pkg::SPEED_W-1:0] peak_q;
	logic signed [afs_pkg::SPEED_W-1:0] roll_q;
	logic [afs_pkg::DIFF_W-1:0]         diff_q;
	logic [afs_pkg::DEN_W-1:0]          den_q;
	logic [afs_pkg::NUM_W-1:0]          numer_q;
	logic signed [afs_pkg::ROLL_TERM_W-1:0] roll_term_q;

	// result register
	logic                               out_valid_q;
	logic signed [afs_pkg::SPEED_W-1:0] flap_command_q;

	// control decoded from the state
	logic in_accept;
	logic out_take;
	logic div_start;
	logic finish;

	logic signed [afs_pkg::CMP_W-1:0]   peak_x, mid_x, max_x, full_x, speed_x, diff_x;
	logic signed [afs_pkg::SPEED_W-1:0] peak_base;
	logic signed [afs_pkg::ROLL_PROD_W-1:0] roll_prod;
	logic [afs_pkg::QUO_W-1:0]          ramp_quo;
	afs_pkg::div_status_t               div_st;
	logic [afs_pkg::QUO_W-1:0]          cmd_base;
	logic signed [afs_pkg::ROLL_TERM_W-1:0] cmd_sub;
	logic signed [afs_pkg::CMD_W-1:0]   cmd_wide;

	assign in_accept = in_valid && !in_stall;
	assign out_take  = out_valid_q && !out_stall;

	// ---------------------------------------------------------------
	// configuration writes, taken whenever the enable is high
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_angle_q <= afs_pkg::FULL_ANGLE_RST;
			speed_mid_q  <= afs_pkg::SPEED_MID_RST;
			speed_max_q  <= afs_pkg::SPEED_MAX_RST;
			roll_gain_q  <= afs_pkg::ROLL_GAIN_RST;
		end else if (cfg_we) begin
			unique case (afs_pkg::cfg_reg_t'(cfg_index))
				afs_pkg::REG_FULL_ANGLE: full_angle_q <= cfg_data[afs_pkg::ANGLE_W-1:0];
				afs_pkg::REG_SPEED_MID:  speed_mid_q  <= cfg_data[afs_pkg::ANGLE_W-1:0];
				afs_pkg::REG_SPEED_MAX:  speed_max_q  <= cfg_data[afs_pkg::ANGLE_W-1:0];
				afs_pkg::REG_ROLL_GAIN:  roll_gain_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// schedule decision at request time, from the peak of earlier samples
	// ---------------------------------------------------------------
	// thresholds scaled to Q8.8 and widened so signed compares are exact
	assign peak_x  = {{2{peak_q[afs_pkg::SPEED_W-1]}}, peak_q};
	assign mid_x   = {2'b00, speed_mid_q, 8'h00};
	assign max_x   = {2'b00, speed_max_q, 8'h00};
	assign full_x  = {2'b00, full_angle_q, 8'h00};
	assign speed_x = {{2{airspeed_sample[afs_pkg::SPEED_W-1]}}, airspeed_sample};
	assign diff_x  = peak_x - mid_x;

	always_comb begin
		cls_d = afs_pkg::CL_NONE;
		if (flight_mode == afs_pkg::MODE_FLYING) begin
			priority if (peak_x > mid_x && peak_x < max_x)
				cls_d = afs_pkg::CL_RAMP;
			else if (peak_x >= max_x)
				cls_d = (roll_angle > 0) ? afs_pkg::CL_FULL_ROLL : afs_pkg::CL_FULL;
			else if (peak_x < mid_x)
				cls_d = afs_pkg::CL_ZERO;
			else
				cls_d = afs_pkg::CL_NONE;  // peak exactly at mid speed
		end else if (flight_mode == afs_pkg::MODE_DEFAULT) begin
			cls_d = afs_pkg::CL_ZERO;
		end
	end

	// default mode drops the peak to its floor before the update
	assign peak_base = (flight_mode == afs_pkg::MODE_DEFAULT) ? afs_pkg::PEAK_FLOOR : peak_q;

	// peak follows the sample upward while it stays under the ceiling;
	// updated at request time since the decision already used the old value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= afs_pkg::PEAK_FLOOR;
		end else if (in_accept) begin
			if (airspeed_sample > peak_base && speed_x < full_x)
				peak_q <= airspeed_sample;
			else
				peak_q <= peak_base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cls_q <= afs_pkg::CL_NONE;
		else if (in_accept)
			cls_q <= cls_d;
	end

	// ---------------------------------------------------------------
	// arithmetic: roll product, ramp numerator, then serial divide
	// ---------------------------------------------------------------
	assign roll_prod = afs_pkg::ROLL_PROD_W'(roll_q)
	                 * afs_pkg::ROLL_PROD_W'($signed({1'b0, roll_gain_q}));

	always_ff @(posedge clk) begin
		if (in_accept) begin
			roll_q <= roll_angle;
			diff_q <= diff_x[afs_pkg::DIFF_W-1:0];  // positive on the ramp
			den_q  <= speed_max_q - speed_mid_q;
		end
		// arithmetic shift gives floor of roll * gain / 256
		if (state_q == afs_pkg::ST_MUL_ROLL)
			roll_term_q <= roll_prod[afs_pkg::ROLL_PROD_W-1:8];
		if (state_q == afs_pkg::ST_MUL_RAMP)
			numer_q <= afs_pkg::NUM_W'(diff_q) * afs_pkg::NUM_W'(full_angle_q);
	end

	afs_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (numer_q),
		.divisor  (den_q),
		.quotient (ramp_quo),
		.status   (div_st)
	);

	// ---------------------------------------------------------------
	// sequencer
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= afs_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			afs_pkg::ST_IDLE:
				if (in_accept)
					state_d = afs_pkg::ST_MUL_ROLL;
			afs_pkg::ST_MUL_ROLL:
				state_d = (cls_q == afs_pkg::CL_RAMP) ? afs_pkg::ST_MUL_RAMP
				                                      : afs_pkg::ST_FINISH;
			afs_pkg::ST_MUL_RAMP:
				state_d = afs_pkg::ST_DIV_GO;
			afs_pkg::ST_DIV_GO:
				state_d = afs_pkg::ST_DIV_WAIT;
			afs_pkg::ST_DIV_WAIT:
				if (div_st.done)
					state_d = afs_pkg::ST_FINISH;
			afs_pkg::ST_FINISH:
				if (!out_valid_q || !out_stall)
					state_d = afs_pkg::ST_IDLE;
			default:
				state_d = afs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = (state_q != afs_pkg::ST_IDLE);
		div_start = (state_q == afs_pkg::ST_DIV_GO);
		// result register must be empty or draining this cycle
		finish    = (state_q == afs_pkg::ST_FINISH) && (!out_valid_q || !out_stall);
	end

	// ---------------------------------------------------------------
	// command assembly and saturation
	// ---------------------------------------------------------------
	always_comb begin
		cmd_base = '0;
		cmd_sub  = '0;
		unique case (cls_q)
			afs_pkg::CL_RAMP: begin
				cmd_base = ramp_quo;
				cmd_sub  = roll_term_q;
			end
			afs_pkg::CL_FULL_ROLL: begin
				cmd_base = {full_angle_q, 8'h00};
				cmd_sub  = roll_term_q;
			end
			afs_pkg::CL_FULL:
				cmd_base = {full_angle_q, 8'h00};
			default: ;
		endcase
	end

	assign cmd_wide = $signed({{(afs_pkg::CMD_W - afs_pkg::QUO_W){1'b0}}, cmd_base})
	                - afs_pkg::CMD_W'(cmd_sub);

	// result register parts the sequencer from the consumer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (finish && cls_q != afs_pkg::CL_NONE)
			out_valid_q <= 1'b1;
		else if (out_take)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (finish && cls_q != afs_pkg::CL_NONE)
			flap_command_q <= afs_pkg::sat16(cmd_wide);
	end

	assign out_valid    = out_valid_q;
	assign flap_command = flap_command_q;

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	// the divider is never restarted while it still iterates
	assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_st.busy)
		else $error("divider restarted while busy");

	// waiting on the divider only makes sense while it runs or just finished
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == afs_pkg::ST_DIV_WAIT) |-> (div_st.busy || div_st.done))
		else $error("waiting on an idle divider");

	// a default-mode sample leaves the peak at the floor or at the sample
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && flight_mode == afs_pkg::MODE_DEFAULT) |=>
		(peak_q == afs_pkg::PEAK_FLOOR || peak_q == $past(airspeed_sample)))
		else $error("peak not reset by default mode");

	// the ramp branch always passes through the divider before finishing
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == afs_pkg::ST_FINISH && $past(state_q) != afs_pkg::ST_FINISH
		 && cls_q == afs_pkg::CL_RAMP) |-> $past(div_st.done))
		else $error("ramp result without a divide");

endmodule
